### src/wes_pkg.sv
// Shared types, constants and op-sequencing functions for the wave stencil block.
package wes_pkg;

	localparam int POINTS_MAX  = 1024;
	localparam int SAMPLE_BITS = 24;
	localparam int IDX_W       = $clog2(POINTS_MAX);
	localparam int MODE_W      = 2;
	localparam int COURANT_W   = 17;
	localparam int TAU_W       = 16;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int STEP_W      = 3;
	localparam int EMIT_W      = 2;
	// operand width: holds a three-point Laplacian and the interim flux
	localparam int D_W         = SAMPLE_BITS + 3;
	localparam int PROD_W      = COURANT_W + 1 + D_W;
	localparam int ACC_W       = PROD_W + 1;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [D_W-1:0]         oper_t;
	typedef logic signed [ACC_W-1:0]       acc_t;

	typedef struct packed {
		sample_t r;
		sample_t s;
		sample_t u;
	} point_t;

	typedef struct packed {
		sample_t r_in;
		sample_t s_in;
		sample_t u_in;
		logic    row_end;
	} wes_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] point_index;
		sample_t          r_out;
		sample_t          s_out;
		sample_t          u_out;
		logic             row_done;
	} wes_result_t;

	// scheme select; the unused code runs Lax-Wendroff
	localparam logic [MODE_W-1:0] MODE_FTCS = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LXF  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LW   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COURANT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TAU     = 2'd2;

	localparam logic [MODE_W-1:0]    MODE_RESET    = MODE_LW;
	localparam logic [COURANT_W-1:0] COURANT_RESET = 17'd65536;
	localparam logic [TAU_W-1:0]     TAU_RESET     = 16'd66;

	typedef enum logic [3:0] {
		OP_R_FT,
		OP_S_FT,
		OP_R_LF,
		OP_S_LF,
		OP_U_FL,
		OP_IR,
		OP_R_LW,
		OP_IS,
		OP_S_LW,
		OP_U_LW
	} wes_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_PUSH,
		ST_DONE
	} wes_state_t;

	typedef struct packed {
		wes_op_t              op;
		point_t               left;
		point_t               center;
		point_t               right;
		logic [COURANT_W-1:0] courant;
		logic [TAU_W-1:0]     tau;
		oper_t                aux;
	} wes_issue_t;

	typedef struct packed {
		logic    valid;
		wes_op_t op;
		oper_t   value;
	} wes_ret_t;

	function automatic logic is_ftcs_lxf(input logic [MODE_W-1:0] mode);
		return (mode == MODE_FTCS) || (mode == MODE_LXF);
	endfunction

	function automatic wes_op_t op_at(input logic [MODE_W-1:0] mode,
			input logic [STEP_W-1:0] step);
		wes_op_t op;
		op = OP_U_LW;
		case (mode)
			MODE_FTCS: begin
				case (step)
					3'd0:    op = OP_R_FT;
					3'd1:    op = OP_S_FT;
					default: op = OP_U_FL;
				endcase
			end
			MODE_LXF: begin
				case (step)
					3'd0:    op = OP_R_LF;
					3'd1:    op = OP_S_LF;
					default: op = OP_U_FL;
				endcase
			end
			default: begin
				case (step)
					3'd0:    op = OP_IR;
					3'd1:    op = OP_R_LW;
					3'd2:    op = OP_IS;
					3'd3:    op = OP_S_LW;
					default: op = OP_U_LW;
				endcase
			end
		endcase
		return op;
	endfunction

	function automatic logic last_step(input logic [MODE_W-1:0] mode,
			input logic [STEP_W-1:0] step);
		return is_ftcs_lxf(mode) ? (step == 3'd2) : (step == 3'd4);
	endfunction

endpackage

### src/wes_alu.sv
// Shared multiply / round / saturate unit, three register stages per op.
module wes_alu (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  wes_pkg::wes_issue_t issue,
	output wes_pkg::wes_ret_t  ret
);

	localparam wes_pkg::acc_t SAT_HI =
		wes_pkg::acc_t'((64'sd1 <<< (wes_pkg::SAMPLE_BITS - 1)) - 64'sd1);
	localparam wes_pkg::acc_t SAT_LO = -SAT_HI - wes_pkg::acc_t'(1);
	localparam wes_pkg::acc_t RND_16 = wes_pkg::acc_t'(64'sd1 <<< 15);
	localparam wes_pkg::acc_t RND_17 = wes_pkg::acc_t'(64'sd1 <<< 16);

	// operand selection
	logic [wes_pkg::COURANT_W-1:0] m_d;
	wes_pkg::oper_t                d_d;
	wes_pkg::oper_t                x_d;
	wes_pkg::sample_t              base_d;

	wes_pkg::oper_t lr, cr, rr, ls, cs, rs;

	logic                          valid_s1;
	wes_pkg::wes_op_t              op_s1;
	logic [wes_pkg::COURANT_W-1:0] m_s1;
	wes_pkg::oper_t                d_s1;
	wes_pkg::oper_t                x_s1;
	wes_pkg::sample_t              base_s1;

	logic                                  valid_s2;
	wes_pkg::wes_op_t                      op_s2;
	logic signed [wes_pkg::PROD_W-1:0]     prod_s2;
	wes_pkg::oper_t                        x_s2;
	wes_pkg::sample_t                      base_s2;

	logic           k16;
	logic           sat_en;
	wes_pkg::acc_t  acc;
	wes_pkg::acc_t  shifted;
	wes_pkg::acc_t  sum;
	wes_pkg::oper_t value_d;

	logic             ret_valid_q;
	wes_pkg::wes_op_t ret_op_q;
	wes_pkg::oper_t   ret_value_q;

	assign lr = wes_pkg::oper_t'(issue.left.r);
	assign cr = wes_pkg::oper_t'(issue.center.r);
	assign rr = wes_pkg::oper_t'(issue.right.r);
	assign ls = wes_pkg::oper_t'(issue.left.s);
	assign cs = wes_pkg::oper_t'(issue.center.s);
	assign rs = wes_pkg::oper_t'(issue.right.s);

	always_comb begin
		m_d    = issue.courant;
		d_d    = '0;
		x_d    = '0;
		base_d = '0;
		case (issue.op)
			wes_pkg::OP_R_FT: begin
				d_d    = rs - ls;
				base_d = issue.center.r;
			end
			wes_pkg::OP_S_FT: begin
				d_d    = rr - lr;
				base_d = issue.center.s;
			end
			wes_pkg::OP_R_LF: begin
				d_d = rs - ls;
				x_d = rr + lr;
			end
			wes_pkg::OP_S_LF: begin
				d_d = rr - lr;
				x_d = rs + ls;
			end
			wes_pkg::OP_U_FL: begin
				m_d    = {1'b0, issue.tau};
				d_d    = cs;
				base_d = issue.center.u;
			end
			wes_pkg::OP_IR: begin
				d_d = rr + lr - (cr <<< 1);
				x_d = rs - ls;
			end
			wes_pkg::OP_R_LW: begin
				d_d    = issue.aux;
				base_d = issue.center.r;
			end
			wes_pkg::OP_IS: begin
				d_d = rs + ls - (cs <<< 1);
				x_d = rr - lr;
			end
			wes_pkg::OP_S_LW: begin
				d_d    = issue.aux;
				base_d = issue.center.s;
			end
			wes_pkg::OP_U_LW: begin
				m_d    = {1'b0, issue.tau};
				d_d    = cs + issue.aux;
				base_d = issue.center.u;
			end
			default: begin
				d_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= issue.op;
		m_s1    <= m_d;
		d_s1    <= d_d;
		x_s1    <= x_d;
		base_s1 <= base_d;
		op_s2   <= op_s1;
		prod_s2 <= $signed({1'b0, m_s1}) * d_s1;
		x_s2    <= x_s1;
		base_s2 <= base_s1;
	end

	// round half up by floor shift, add the center term, then clamp all but the interim fluxes
	always_comb begin
		k16 = (op_s2 == wes_pkg::OP_U_FL) || (op_s2 == wes_pkg::OP_R_LW) ||
			(op_s2 == wes_pkg::OP_S_LW);
		sat_en = (op_s2 != wes_pkg::OP_IR) && (op_s2 != wes_pkg::OP_IS);
		acc = wes_pkg::acc_t'(prod_s2) + (wes_pkg::acc_t'(x_s2) <<< 16) +
			(k16 ? RND_16 : RND_17);
		shifted = k16 ? (acc >>> 16) : (acc >>> 17);
		sum     = shifted + wes_pkg::acc_t'(base_s2);
		if (!sat_en) begin
			value_d = wes_pkg::oper_t'(sum);
		end else if (sum > SAT_HI) begin
			value_d = wes_pkg::oper_t'(SAT_HI);
		end else if (sum < SAT_LO) begin
			value_d = wes_pkg::oper_t'(SAT_LO);
		end else begin
			value_d = wes_pkg::oper_t'(sum);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_valid_q <= 1'b0;
		end else begin
			ret_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		ret_op_q    <= op_s2;
		ret_value_q <= value_d;
	end

	assign ret = '{valid: ret_valid_q, op: ret_op_q, value: ret_value_q};

endmodule

### src/wave_equation_stencil_step.sv
// Top level: periodic 1D wave stencil step with a sequencer over one shared multiply unit.
// Each op passes through the shared unit in turn; a result word takes 3 ops (FTCS, Lax-Friedrichs)
// or 5 ops (Lax-Wendroff), then the output register loads once it is free.
// An item gives 0 to 3 result words, worked one after another; no new item is taken
// until all of them are out.
// Reset clears the row state to zero, point count to 0, and loads scheme Lax-Wendroff,
// courant 1.0 and time step 66; no clearing pass.
module wave_equation_stencil_step (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  wes_pkg::wes_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output wes_pkg::wes_result_t            result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [wes_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [wes_pkg::CFG_W-1:0]       cfg_data
);

	// configuration
	logic [wes_pkg::MODE_W-1:0]    mode_q;
	logic [wes_pkg::COURANT_W-1:0] courant_q;
	logic [wes_pkg::TAU_W-1:0]     tau_q;

	// row state: points 0 and 1, sliding window of k-2 and k-1
	wes_pkg::point_t           first_q, second_q, older_q, prev_q;
	logic [wes_pkg::IDX_W-1:0] count_q;

	// item under work
	wes_pkg::point_t            cur_q;
	logic                       last_q;
	logic [wes_pkg::EMIT_W-1:0] n_emit_q;
	logic [wes_pkg::EMIT_W-1:0] emit_q;
	logic [wes_pkg::STEP_W-1:0] step_q;

	// per-word results collected from the shared unit
	wes_pkg::sample_t r_q, s_q, u_q;
	wes_pkg::oper_t   aux_q;

	wes_pkg::wes_result_t out_q;
	logic                 out_valid_q;

	wes_pkg::wes_state_t state_q, state_d;

	logic                       accept;
	logic                       item_last;
	logic [wes_pkg::EMIT_W-1:0] item_n_emit;
	logic                       issue_start;
	logic                       push_load;
	logic                       final_emit;
	wes_pkg::wes_issue_t        issue;
	wes_pkg::wes_ret_t          ret;

	wes_pkg::point_t           nb_left, nb_center, nb_right;
	logic [wes_pkg::IDX_W-1:0] nb_index;
	logic                      nb_done;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= wes_pkg::MODE_RESET;
			courant_q <= wes_pkg::COURANT_RESET;
			tau_q     <= wes_pkg::TAU_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				wes_pkg::CFG_MODE:    mode_q    <= cfg_data[wes_pkg::MODE_W-1:0];
				wes_pkg::CFG_COURANT: courant_q <= cfg_data[wes_pkg::COURANT_W-1:0];
				wes_pkg::CFG_TAU:     tau_q     <= cfg_data[wes_pkg::TAU_W-1:0];
				default:              ; // drop writes to unknown registers
			endcase
		end
	end

	// A point ends the row on its flag or when the index space is used up.
	// Results released: point 0 alone gives its own wrapped result only on a
	// one-point row, point 1 gives two on a two-point row, later points give
	// one, and the row's last point gives three.
	assign accept    = item_valid && item_ready;
	assign item_last = item.row_end ||
		(count_q == wes_pkg::IDX_W'(wes_pkg::POINTS_MAX - 1));

	always_comb begin
		case (count_q)
			wes_pkg::IDX_W'(0): item_n_emit = item_last ? 2'd1 : 2'd0;
			wes_pkg::IDX_W'(1): item_n_emit = item_last ? 2'd2 : 2'd0;
			default:            item_n_emit = item_last ? 2'd3 : 2'd1;
		endcase
	end

	// Neighbors of the word in progress. The ring wraps through points 0
	// and 1; the word for point 0 always goes out last and flags the row end.
	always_comb begin
		nb_left   = cur_q;
		nb_center = cur_q;
		nb_right  = cur_q;
		nb_index  = '0;
		nb_done   = 1'b1;
		case (count_q)
			wes_pkg::IDX_W'(0): begin
				nb_done = 1'b1;
			end
			wes_pkg::IDX_W'(1): begin
				if (emit_q == 2'd0) begin
					nb_left   = first_q;
					nb_center = cur_q;
					nb_right  = first_q;
					nb_index  = wes_pkg::IDX_W'(1);
					nb_done   = 1'b0;
				end else begin
					nb_left   = cur_q;
					nb_center = first_q;
					nb_right  = cur_q;
				end
			end
			default: begin
				case (emit_q)
					2'd0: begin
						nb_left   = older_q;
						nb_center = prev_q;
						nb_right  = cur_q;
						nb_index  = count_q - wes_pkg::IDX_W'(1);
						nb_done   = 1'b0;
					end
					2'd1: begin
						nb_left   = prev_q;
						nb_center = cur_q;
						nb_right  = first_q;
						nb_index  = count_q;
						nb_done   = 1'b0;
					end
					default: begin
						nb_left   = cur_q;
						nb_center = first_q;
						nb_right  = second_q;
					end
				endcase
			end
		endcase
	end

	assign issue.op      = wes_pkg::op_at(mode_q, step_q);
	assign issue.left    = nb_left;
	assign issue.center  = nb_center;
	assign issue.right   = nb_right;
	assign issue.courant = courant_q;
	assign issue.tau     = tau_q;
	assign issue.aux     = aux_q;

	wes_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (issue_start),
		.issue  (issue),
		.ret    (ret)
	);

	assign final_emit = (emit_q == n_emit_q - 2'd1);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			wes_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = (item_n_emit != 2'd0) ? wes_pkg::ST_ISSUE : wes_pkg::ST_DONE;
				end
			end
			wes_pkg::ST_ISSUE: begin
				state_d = wes_pkg::ST_WAIT;
			end
			wes_pkg::ST_WAIT: begin
				if (ret.valid) begin
					state_d = wes_pkg::last_step(mode_q, step_q) ? wes_pkg::ST_PUSH :
						wes_pkg::ST_ISSUE;
				end
			end
			wes_pkg::ST_PUSH: begin
				if (!out_valid_q || result_ready) begin
					state_d = final_emit ? wes_pkg::ST_DONE : wes_pkg::ST_ISSUE;
				end
			end
			wes_pkg::ST_DONE: begin
				state_d = wes_pkg::ST_IDLE;
			end
			default: begin
				state_d = wes_pkg::ST_IDLE;
			end
		endcase
	end

	// state outputs
	always_comb begin
		item_ready  = 1'b0;
		issue_start = 1'b0;
		push_load   = 1'b0;
		case (state_q)
			wes_pkg::ST_IDLE:  item_ready  = 1'b1;
			wes_pkg::ST_ISSUE: issue_start = 1'b1;
			wes_pkg::ST_PUSH:  push_load   = !out_valid_q || result_ready;
			default:           item_ready  = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wes_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			count_q     <= '0;
			emit_q      <= '0;
			step_q      <= '0;
			first_q     <= '0;
			second_q    <= '0;
			older_q     <= '0;
			prev_q      <= '0;
		end else begin
			state_q <= state_d;

			// hold the output word until taken; reload it straight away if free
			if (push_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				emit_q <= '0;
				step_q <= '0;
			end
			if (state_q == wes_pkg::ST_WAIT && ret.valid &&
					!wes_pkg::last_step(mode_q, step_q)) begin
				step_q <= step_q + 3'd1;
			end
			if (push_load) begin
				step_q <= '0;
				emit_q <= emit_q + 2'd1;
			end

			// advance the window once all words of the point are out
			if (state_q == wes_pkg::ST_DONE) begin
				case (count_q)
					wes_pkg::IDX_W'(0): begin
						first_q <= cur_q;
						prev_q  <= cur_q;
					end
					wes_pkg::IDX_W'(1): begin
						second_q <= cur_q;
						older_q  <= prev_q;
						prev_q   <= cur_q;
					end
					default: begin
						older_q <= prev_q;
						prev_q  <= cur_q;
					end
				endcase
				count_q <= last_q ? '0 : count_q + wes_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q.r  <= item.r_in;
			cur_q.s  <= item.s_in;
			cur_q.u  <= item.u_in;
			last_q   <= item_last;
			n_emit_q <= item_n_emit;
		end
		// every return feeds the next op; the interim fluxes and s' travel in aux
		if (ret.valid) begin
			aux_q <= ret.value;
			case (ret.op)
				wes_pkg::OP_R_FT,
				wes_pkg::OP_R_LF,
				wes_pkg::OP_R_LW: r_q <= ret.value[wes_pkg::SAMPLE_BITS-1:0];
				wes_pkg::OP_S_FT,
				wes_pkg::OP_S_LF,
				wes_pkg::OP_S_LW: s_q <= ret.value[wes_pkg::SAMPLE_BITS-1:0];
				wes_pkg::OP_U_FL,
				wes_pkg::OP_U_LW: u_q <= ret.value[wes_pkg::SAMPLE_BITS-1:0];
				default:          ; // interim flux only
			endcase
		end
		if (push_load) begin
			out_q.point_index <= nb_index;
			out_q.r_out       <= r_q;
			out_q.s_out       <= s_q;
			out_q.u_out       <= u_q;
			out_q.row_done    <= nb_done;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### test/tb_top.sv
// Self-checking testbench for the periodic 1D wave stencil step block.
module tb_top;
	import wes_pkg::*;

	// mode code with no scheme of its own; the block runs Lax-Wendroff on it
	localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	// the pause before a register write covers the block's slowest item
	localparam int SETTLE_CYCLES = 100;
	localparam int LONG_HOLD     = 600;
	localparam int QUIET_LIMIT   = 5000;
	localparam int PHASE_POINTS  = 50;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  item_valid = 1'b0;
	logic                  item_ready;
	wes_item_t             item_w = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	wes_result_t           result_w;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;

	wave_equation_stencil_step u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item_w),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result_w),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	typedef struct {
		logic [CFG_IDX_W-1:0] idx;
		logic [CFG_W-1:0]     data;
	} reg_write_t;

	// grid points waiting to be sent, register writes waiting, next-row words predicted
	wes_item_t   grid_q[$];
	reg_write_t  reg_q[$];
	wes_result_t next_row_q[$];

	// shadow of the block's registers and row state
	logic [MODE_W-1:0]    cur_mode    = MODE_RESET;
	logic [COURANT_W-1:0] cur_courant = COURANT_RESET;
	logic [TAU_W-1:0]     cur_tau     = TAU_RESET;
	point_t               row_first, row_second, row_older, row_prev;
	int                   pt_count;

	int errors       = 0;
	int points_in    = 0;
	int words_seen   = 0;
	int rows_closed  = 0;
	int holds_done   = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Next-row predictor
	// ---------------------------------------------------------------

	// round half up: floor((v + 2^(k-1)) / 2^k)
	function automatic longint round_shift(input longint v, input int k);
		return (v + (longint'(1) <<< (k - 1))) >>> k;
	endfunction

	function automatic longint clamp(input longint v);
		if (v > SAT_HI)
			return SAT_HI;
		if (v < SAT_LO)
			return SAT_LO;
		return v;
	endfunction

	// one updated point from its left neighbour, itself and its right neighbour
	function automatic wes_result_t stencil(input point_t lp, input point_t cp, input point_t rp,
			input int idx, input logic done);
		longint c, tau, l_r, l_s, c_r, c_s, c_u, r_r, r_s;
		longint flux_r, flux_s, rn, sn, un;
		wes_result_t res;
		c   = cur_courant;
		tau = cur_tau;
		l_r = lp.r;
		l_s = lp.s;
		c_r = cp.r;
		c_s = cp.s;
		c_u = cp.u;
		r_r = rp.r;
		r_s = rp.s;
		case (cur_mode)
			MODE_FTCS: begin
				rn = clamp(c_r + round_shift(c * (r_s - l_s), 17));
				sn = clamp(c_s + round_shift(c * (r_r - l_r), 17));
				un = clamp(c_u + round_shift(tau * c_s, 16));
			end
			MODE_LXF: begin
				rn = clamp(round_shift((r_r + l_r) * 65536 + c * (r_s - l_s), 17));
				sn = clamp(round_shift((r_s + l_s) * 65536 + c * (r_r - l_r), 17));
				un = clamp(c_u + round_shift(tau * c_s, 16));
			end
			default: begin
				// Lax-Wendroff; the spare code lands here too
				flux_r = round_shift((r_s - l_s) * 65536 + c * (r_r + l_r - 2 * c_r), 17);
				flux_s = round_shift((r_r - l_r) * 65536 + c * (r_s + l_s - 2 * c_s), 17);
				rn = clamp(c_r + round_shift(c * flux_r, 16));
				sn = clamp(c_s + round_shift(c * flux_s, 16));
				// u takes the already saturated s
				un = clamp(c_u + round_shift(tau * (c_s + sn), 17));
			end
		endcase
		res.point_index = IDX_W'(idx);
		res.r_out       = sample_t'(rn);
		res.s_out       = sample_t'(sn);
		res.u_out       = sample_t'(un);
		res.row_done    = done;
		return res;
	endfunction

	// take one accepted grid point, queue the next-row words it releases
	task automatic advance_row(input wes_item_t it);
		point_t cp;
		logic   last;
		int     k;
		cp.r = it.r_in;
		cp.s = it.s_in;
		cp.u = it.u_in;
		k    = pt_count;
		// the point at the top index closes the row whatever row_end says
		last = it.row_end || (k >= POINTS_MAX - 1);
		if (k == 0) begin
			row_first = cp;
			row_prev  = cp;
			if (last) begin
				// one-point row: the point is its own neighbour on both sides
				next_row_q.push_back(stencil(cp, cp, cp, 0, 1'b1));
				rows_closed++;
				pt_count = 0;
			end else begin
				pt_count = 1;
			end
		end else if (k == 1) begin
			row_second = cp;
			row_older  = row_prev;
			row_prev   = cp;
			if (last) begin
				// two-point row: the other point flanks each side
				next_row_q.push_back(stencil(row_first, cp, row_first, 1, 1'b0));
				next_row_q.push_back(stencil(cp, row_first, cp, 0, 1'b1));
				rows_closed++;
				pt_count = 0;
			end else begin
				pt_count = 2;
			end
		end else begin
			next_row_q.push_back(stencil(row_older, row_prev, cp, k - 1, 1'b0));
			if (last) begin
				// wrap: last point, then point 0 closes the row
				next_row_q.push_back(stencil(row_prev, cp, row_first, k, 1'b0));
				next_row_q.push_back(stencil(cp, row_first, row_second, 0, 1'b1));
				rows_closed++;
				pt_count = 0;
			end else begin
				row_older = row_prev;
				row_prev  = cp;
				pt_count  = k + 1;
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Point driver: bursts of random length, random gaps between them
	// ---------------------------------------------------------------
	int burst_left = 1;
	int gap_left   = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				advance_row(item_w);
				points_in++;
			end
			// hold the word until it is taken
			if (!item_valid || item_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					item_valid <= 1'b0;
				end else if (grid_q.size() > 0) begin
					item_valid <= 1'b1;
					item_w     <= grid_q.pop_front();
					burst_left--;
					if (burst_left <= 0) begin
						// now and then a long burst with no idling at all
						burst_left = ($urandom_range(0, 4) == 0) ?
								$urandom_range(40, 120) : $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
					end
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Register write driver
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MODE:    cur_mode    = cfg_data[MODE_W-1:0];
					CFG_COURANT: cur_courant = cfg_data[COURANT_W-1:0];
					CFG_TAU:     cur_tau     = cfg_data[TAU_W-1:0];
					default:     ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_q.size() > 0) begin
					reg_write_t w;
					w = reg_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data  <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Result receiver: stall pattern of its own, plus long hold-offs
	// ---------------------------------------------------------------
	int hold_left = 0;
	int pat_left  = 0;
	int pat_kind  = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (holds_done < 2 && words_seen > 40 + 300 * holds_done &&
				grid_q.size() > 16) begin
			// hold off while points keep coming so the block backs up
			hold_left = LONG_HOLD;
			holds_done++;
			result_ready <= 1'b0;
		end else begin
			if (pat_left <= 0) begin
				pat_kind = $urandom_range(0, 3);
				pat_left = $urandom_range(4, 40);
			end
			pat_left--;
			case (pat_kind)
				0, 1:    result_ready <= 1'b1;
				2:       result_ready <= $urandom_range(0, 1);
				default: result_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Monitor: compare each word with the oldest prediction
	// ---------------------------------------------------------------
	wes_result_t want;

	task automatic check_field(input string what, input longint exp_v, input longint got_v);
		if (exp_v != got_v) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (next_row_q.size() == 0) begin
				errors++;
				$display("%0t: word with nothing predicted, got index %0d r %0d s %0d u %0d",
						$time, result_w.point_index, result_w.r_out, result_w.s_out,
						result_w.u_out);
			end else begin
				want = next_row_q.pop_front();
				check_field("point_index", want.point_index, result_w.point_index);
				check_field("r_out", want.r_out, result_w.r_out);
				check_field("s_out", want.s_out, result_w.s_out);
				check_field("u_out", want.u_out, result_w.u_out);
				check_field("row_done", want.row_done, result_w.row_done);
			end
			words_seen++;
		end
	end

	// ---------------------------------------------------------------
	// Watchdog: drop the run when no handshake happens for too long
	// ---------------------------------------------------------------
	int quiet = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready) ||
					(cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("%0t: no handshake for %0d cycles, %0d words still predicted",
							$time, quiet, next_row_q.size());
					$display("tb_top: errors");
					$finish;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus sequence
	// ---------------------------------------------------------------
	function automatic wes_item_t make_point(input sample_t r, input sample_t s,
			input sample_t u, input logic row_end);
		wes_item_t it;
		it.r_in    = r;
		it.s_in    = s;
		it.u_in    = u;
		it.row_end = row_end;
		return it;
	endfunction

	function automatic sample_t rand_sample();
		case ($urandom_range(0, 9))
			0:       return SAMPLE_MAX;
			1:       return SAMPLE_MIN;
			2:       return '0;
			3:       return sample_t'(int'($urandom_range(0, 4000)) - 2000);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// queue a row of random points; mark_end off leaves row_end low throughout
	task automatic push_row(input int len, input logic mark_end);
		for (int i = 0; i < len; i++)
			grid_q.push_back(make_point(rand_sample(), rand_sample(), rand_sample(),
					mark_end && (i == len - 1)));
	endtask

	// wait until every word is out, then give the block time to finish its last point
	task automatic drain();
		@(negedge clk);
		while (grid_q.size() != 0 || item_valid || next_row_q.size() != 0 ||
				reg_q.size() != 0 || cfg_valid)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		reg_write_t w;
		w.idx  = idx;
		w.data = CFG_W'(value);
		reg_q.push_back(w);
	endtask

	initial begin
		logic [MODE_W-1:0] m;
		int unsigned       cv, tv;
		int                phase_pts, len;

		pt_count   = 0;
		row_first  = '0;
		row_second = '0;
		row_older  = '0;
		row_prev   = '0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed rows under reset settings: one, two, three and five points at the extremes
		grid_q.push_back(make_point(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1));
		grid_q.push_back(make_point(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
		grid_q.push_back(make_point(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 1'b1));
		grid_q.push_back(make_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, 1'b0));
		grid_q.push_back(make_point(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, 1'b0));
		grid_q.push_back(make_point('0, '0, '0, 1'b1));
		grid_q.push_back(make_point('0, '0, '0, 1'b1));
		grid_q.push_back(make_point(SAMPLE_MIN, SAMPLE_MAX, '0, 1'b0));
		grid_q.push_back(make_point(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
		grid_q.push_back(make_point('1, '1, '1, 1'b0));
		grid_q.push_back(make_point(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, 1'b0));
		grid_q.push_back(make_point(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, 1'b1));
		drain();

		// phases over schemes, courant and time step, extremes among them
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					m  = MODE_FTCS;
					cv = $urandom_range(1, 65535);
					tv = $urandom_range(0, 65535);
				end
				1: begin
					m  = MODE_LXF;
					cv = 65536;
					tv = 65535;
				end
				2: begin
					m  = MODE_LW;
					cv = 0;
					tv = 0;
				end
				3: begin
					// spare code with courant above one
					m  = MODE_SPARE;
					cv = 131071;
					tv = $urandom_range(0, 65535);
				end
				4: begin
					m  = MODE_LW;
					cv = $urandom_range(0, 65536);
					tv = $urandom_range(0, 65535);
				end
				5: begin
					m  = MODE_FTCS;
					cv = 131071;
					tv = 0;
				end
				6: begin
					m  = MODE_LXF;
					cv = 0;
					tv = 65535;
				end
				default: begin
					m  = MODE_LW;
					cv = COURANT_RESET;
					tv = TAU_RESET;
				end
			endcase
			write_reg(CFG_MODE, m);
			write_reg(CFG_COURANT, cv);
			write_reg(CFG_TAU, tv);
			drain();

			phase_pts = 0;
			while (phase_pts < PHASE_POINTS) begin
				case ($urandom_range(0, 19))
					0:       len = $urandom_range(1, 2);
					1, 2, 3: len = $urandom_range(9, 40);
					default: len = $urandom_range(1, 8);
				endcase
				push_row(len, 1'b1);
				phase_pts += len;
			end
			drain();
		end

		$display("run covered %0d grid points, %0d next-row words, %0d rows closed",
				points_in, words_seen, rows_closed);
		$display("all four mode codes, courant 0 to above one, time step 0 to max, %0d long holds",
				holds_done);
		if (errors == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
